>>> hw/rtl/aogt_pkg.sv
package aogt_pkg;

    localparam int GAIN_SETTINGS_DEFAULT = 5;

    localparam int CMD_W      = 2;
    localparam int SEL_W      = 3;
    localparam int CODE_W     = 16;
    localparam int PRESENT_W  = 15;
    localparam int VOLT_W     = 17;
    localparam int TRIM_W     = 17;
    localparam int OFFSET_W   = 15;
    localparam int GAIN_W     = 17;
    localparam int REF_W      = 18;
    localparam int BIAS_W     = 17;
    localparam int PGA_W      = 5;

    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 5;
    localparam int M_TDATA_W  = 56;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_REF_SCALE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS      = 1'b1;

    localparam logic [REF_W-1:0]  REF_SCALE_RESET = 18'd119276;
    localparam logic [BIAS_W-1:0] BIAS_RESET      = 17'd72745;

    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFSET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GAIN   = 2'd2;

    localparam logic [TRIM_W-1:0] ILLEGAL_GAIN_CODE = 17'h14000;
    localparam logic [GAIN_W-1:0] UNITY_GAIN        = 17'h04000;

    // shared divider sizing
    localparam int NUM_MAG_W   = 37;
    localparam int DIVIDEND_W  = 46;
    localparam int DIVISOR_W   = 19;
    localparam int STEP_W      = 6;
    localparam logic [STEP_W-1:0] DIV1_STEPS = 6'(NUM_MAG_W);
    localparam logic [STEP_W-1:0] DIV2_STEPS = 6'(DIVIDEND_W);

    typedef struct packed {
        logic calc_off;
        logic calc_num;
        logic div_start;
        logic div_sel;
        logic calc_mul;
        logic calc_gain;
        logic write_bank;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic             div_done;
        logic             out_free;
        logic [CMD_W-1:0] kind;
    } t_dp_stat;

    // pga gain times two
    function automatic logic [PGA_W-1:0] pga_twice(input logic [SEL_W-1:0] sel);
        logic [PGA_W-1:0] g;
        case (sel)
            3'd0:    g = 5'd2;
            3'd1:    g = 5'd3;
            3'd2:    g = 5'd4;
            3'd3:    g = 5'd8;
            3'd4:    g = 5'd18;
            default: g = 5'd2;
        endcase
        return g;
    endfunction

endpackage

>>> hw/rtl/aogt_divider.sv
module aogt_divider
    import aogt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [STEP_W-1:0]     i_steps,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quot
);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [STEP_W-1:0]     r_count;
    logic                  r_done;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;
    logic [DIVISOR_W-1:0]  n_rem;

    always_comb begin
        shifted = {r_rem, r_quot[DIVIDEND_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_dvs};
        fits    = ~trial[DIVISOR_W+1];
        n_rem   = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_rem   <= '0;
            r_quot  <= i_dividend;
            r_dvs   <= i_divisor;
            r_count <= i_steps;
            r_done  <= 1'b0;
        end else if (r_count != '0) begin
            r_rem   <= n_rem;
            r_quot  <= {r_quot[DIVIDEND_W-2:0], fits};
            r_count <= r_count - 1'b1;
            r_done  <= (r_count == STEP_W'(1));
        end else begin
            r_done  <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> hw/rtl/aogt_datapath.sv
module aogt_datapath
    import aogt_pkg::*;
#(
    parameter int GAIN_SETTINGS = GAIN_SETTINGS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_accept,
    input  logic [S_TUSER_W-1:0]   i_tuser,
    input  logic [S_TDATA_W-1:0]   i_tdata,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [M_TDATA_W-1:0]   o_m_tdata,
    output logic [M_TUSER_W-1:0]   o_m_tuser
);

    localparam int SlotW = (GAIN_SETTINGS > 1) ? $clog2(GAIN_SETTINGS) : 1;

    logic [REF_W-1:0]     r_ref_scale;
    logic [BIAS_W-1:0]    r_bias;

    logic [CMD_W-1:0]     r_cmd;
    logic [SEL_W-1:0]     r_sel;
    logic [CODE_W-1:0]    r_code;
    logic [PRESENT_W-1:0] r_present;
    logic [VOLT_W-1:0]    r_vt;

    logic [TRIM_W-1:0]    r_trim;
    logic                 r_illegal;
    logic                 r_clamped;

    logic                 r_num_neg;
    logic [NUM_MAG_W-1:0] r_num_mag;
    logic                 r_den_zero;
    logic [DIVIDEND_W-1:0] r_prod;
    logic                 r_eq;
    logic                 r_qneg;

    logic [OFFSET_W-1:0]  r_off_bank  [GAIN_SETTINGS];
    logic [GAIN_W-1:0]    r_gain_bank [GAIN_SETTINGS];

    logic                 r_out_valid;
    logic [TRIM_W-1:0]    r_out_trim;
    logic [OFFSET_W-1:0]  r_out_off;
    logic [GAIN_W-1:0]    r_out_gain;
    logic                 r_out_illegal;
    logic                 r_out_clamped;

    logic                 has_entry;
    logic [SlotW-1:0]     slot;

    // offset adjust
    logic                 code_mid;
    logic                 code_hi;
    logic [15:0]          lo_diff;
    logic [16:0]          off_t_hi;
    logic [17:0]          off_t_lo;
    logic [18:0]          off_wrap;
    logic [18:0]          off_sum;
    logic [TRIM_W-1:0]    off_trim;
    logic                 off_clamp;

    // gain adjust
    logic [PGA_W-1:0]     pga2;
    logic signed [17:0]   vdiff;
    logic signed [23:0]   vscaled;
    logic signed [38:0]   num_ext;
    logic signed [38:0]   num;
    logic [38:0]          num_abs;
    logic                 meas_neg;
    logic [15:0]          meas_mag;
    logic [NUM_MAG_W-1:0] tmag;
    logic [30:0]          tsat;
    logic [DIVIDEND_W-1:0] prod;
    logic                 q_legal;
    logic                 gain_ok;
    logic [TRIM_W-1:0]    gain_trim;

    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [STEP_W-1:0]     div_steps;

    always_comb begin
        has_entry = {1'b0, r_sel} < 4'(GAIN_SETTINGS);
        slot      = has_entry ? r_sel[SlotW-1:0] : '0;
    end

    always_comb begin
        code_mid  = (r_code == 16'h8000);
        code_hi   = r_code[15] && !code_mid;
        lo_diff   = 16'(17'h08000 - {1'b0, r_code});
        off_t_hi  = {r_code[14:0], 2'b00};
        off_t_lo  = {lo_diff, 2'b00};
        off_wrap  = 19'h07FFF - {2'b00, off_t_hi} + {4'b0000, r_present};
        off_sum   = {4'b0000, r_present} + {1'b0, off_t_lo};
        off_clamp = 1'b0;
        if (code_hi) begin
            if ({2'b00, r_present} >= off_t_hi) begin
                off_trim = {2'b00, r_present} - off_t_hi;
            end else if (off_wrap[18] || (off_wrap[17:0] < 18'h04000)) begin
                off_trim  = 17'h04000;
                off_clamp = 1'b1;
            end else begin
                off_trim = off_wrap[16:0];
            end
        end else if (!code_mid) begin
            off_trim = (off_sum > 19'h03FFF) ? 17'h03FFF : off_sum[16:0];
        end else begin
            off_trim = {2'b00, r_present};
        end
    end

    always_comb begin
        pga2     = pga_twice(r_sel);
        vdiff    = $signed({1'b0, r_vt} - {1'b0, r_bias});
        vscaled  = vdiff * $signed({1'b0, pga2});
        num_ext  = 39'(vscaled);
        num      = (num_ext <<< 15) - num_ext;
        num_abs  = num[38] ? 39'(-num) : 39'(num);
        meas_neg = ~r_code[15];
        meas_mag = r_code[15] ? {1'b0, r_code[14:0]} : lo_diff;
        tmag     = div_quot[NUM_MAG_W-1:0];
        tsat     = (|tmag[NUM_MAG_W-1:31]) ? '1 : tmag[30:0];
        prod     = DIVIDEND_W'(r_present) * DIVIDEND_W'(tsat);
        q_legal  = (meas_mag != '0) && !r_qneg && (div_quot != '0)
                   && (div_quot <= DIVIDEND_W'(17'h08000));
        gain_ok  = !r_den_zero && (r_eq ? (r_present != '0) : q_legal);
        if (!gain_ok) begin
            gain_trim = ILLEGAL_GAIN_CODE;
        end else if (r_eq) begin
            gain_trim = {2'b00, r_present};
        end else begin
            gain_trim = div_quot[TRIM_W-1:0];
        end
    end

    always_comb begin
        if (i_cmd.div_sel) begin
            div_dividend = r_prod;
            div_divisor  = {3'b000, meas_mag};
            div_steps    = DIV2_STEPS;
        end else begin
            div_dividend = {r_num_mag, {(DIVIDEND_W-NUM_MAG_W){1'b0}}};
            div_divisor  = {r_ref_scale, 1'b0};
            div_steps    = DIV1_STEPS;
        end
    end

    aogt_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_steps    (div_steps),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_scale <= REF_SCALE_RESET;
            r_bias      <= BIAS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_REF_SCALE: r_ref_scale <= i_cfg_data;
                CFG_BIAS:      r_bias      <= i_cfg_data[BIAS_W-1:0];
                default:       r_bias      <= r_bias;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd     <= i_tuser[CMD_W-1:0];
            r_sel     <= i_tuser[CMD_W +: SEL_W];
            r_code    <= i_tdata[CODE_W-1:0];
            r_present <= i_tdata[CODE_W +: PRESENT_W];
            r_vt      <= i_tdata[CODE_W+PRESENT_W +: VOLT_W];
            r_trim    <= '0;
            r_illegal <= 1'b0;
            r_clamped <= 1'b0;
        end
        if (i_cmd.calc_off) begin
            r_trim    <= off_trim;
            r_clamped <= off_clamp;
        end
        if (i_cmd.calc_num) begin
            r_num_neg  <= num[38];
            r_num_mag  <= num_abs[NUM_MAG_W-1:0];
            r_den_zero <= (r_ref_scale == '0);
        end
        if (i_cmd.calc_mul) begin
            r_prod <= prod;
            r_eq   <= (tmag == NUM_MAG_W'(meas_mag)) && ((r_num_neg == meas_neg) || (tmag == '0));
            r_qneg <= (tmag != '0) && (r_num_neg ^ meas_neg);
        end
        if (i_cmd.calc_gain) begin
            r_trim    <= gain_trim;
            r_illegal <= !gain_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GAIN_SETTINGS; i++) begin
                r_off_bank[i]  <= '0;
                r_gain_bank[i] <= UNITY_GAIN;
            end
        end else if (i_cmd.write_bank && has_entry) begin
            if (r_cmd == CMD_OFFSET) begin
                r_off_bank[slot] <= r_trim[OFFSET_W-1:0];
            end
            if (r_cmd == CMD_GAIN) begin
                r_gain_bank[slot] <= r_trim;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid   <= 1'b1;
            r_out_trim    <= r_trim;
            r_out_off     <= r_off_bank[slot];
            r_out_gain    <= r_gain_bank[slot];
            r_out_illegal <= r_illegal;
            r_out_clamped <= r_clamped;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || i_m_tready;
        o_stat.kind     = r_cmd;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-TRIM_W-OFFSET_W-GAIN_W){1'b0}},
                         r_out_gain, r_out_off, r_out_trim};
    assign o_m_tuser  = {r_out_clamped, r_out_illegal};

endmodule

>>> hw/rtl/aogt_ctrl.sv
module aogt_ctrl
    import aogt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_ready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OFFSET,
        S_GNUM,
        S_DIV1S,
        S_DIV1,
        S_MUL,
        S_DIV2S,
        S_DIV2,
        S_GFIN,
        S_WRITE,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    CMD_OFFSET: n_state = S_OFFSET;
                    CMD_GAIN:   n_state = S_GNUM;
                    default:    n_state = S_WRITE;
                endcase
            end
            S_OFFSET: begin
                o_cmd.calc_off = 1'b1;
                n_state        = S_WRITE;
            end
            S_GNUM: begin
                o_cmd.calc_num = 1'b1;
                n_state        = S_DIV1S;
            end
            S_DIV1S: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV1;
            end
            S_DIV1: begin
                if (i_stat.div_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state        = S_DIV2S;
            end
            S_DIV2S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = 1'b1;
                n_state         = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_sel = 1'b1;
                if (i_stat.div_done) n_state = S_GFIN;
            end
            S_GFIN: begin
                o_cmd.calc_gain = 1'b1;
                n_state         = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.write_bank = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_ready = r_ready;

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> (r_state == S_IDLE))
        else $error("item taken while busy");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("output overwritten");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1S) |=> ((r_state == S_DIV1) && !i_stat.div_done))
        else $error("divider done too early");

endmodule

>>> hw/rtl/adc_offset_gain_trim_engine.sv
// adc offset and gain trim engine
// keeps one offset trim and one gain trim per pga gain setting
// input stream: s_axis_tuser selects the operation and gain index, s_axis_tdata
//   carries the adc code, the present trim and the target voltage
// output stream: one item per input item with the new trim, both stored trims
//   for the selected gain and the illegal-gain and offset-clamped flags
// config channel: i_cfg_index 0 writes reference_scale, 1 writes bias_voltage;
//   ready whenever out of reset, write only while no item is in flight
// a read passes dispatch, write and output; offset adjust adds the offset step,
//   gain adjust numerator, divider, multiply and final steps; one item is worked
//   on at a time, the next is taken the cycle after the result is registered
// gain adjust time is set by the shared restoring divider: 37 steps for the
//   target code, 46 steps for the scaled trim
// the result sits in an output register; a stalled receiver holds it there
//   and the block may take the next item, which then waits before its
//   result is loaded
// reset: both banks return to offset 0 and unity gain 0x4000, the config
//   registers to their defaults, output empty
module adc_offset_gain_trim_engine
    import aogt_pkg::*;
#(
    parameter int GAIN_SETTINGS = GAIN_SETTINGS_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // adc_code, present_value, target_voltage
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // command, gain_select
    input  logic [S_TUSER_W-1:0]   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // new_trim, stored_offset, stored_gain, zero fill
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // illegal_gain, offset_clamped
    output logic [M_TUSER_W-1:0]   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_ready;
    logic     w_accept;

    assign w_accept      = s_axis_tvalid && w_ready;
    assign s_axis_tready = w_ready;
    assign o_cfg_ready   = i_rst_n;

    aogt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_ready  (w_ready)
    );

    aogt_datapath #(
        .GAIN_SETTINGS (GAIN_SETTINGS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_tuser     (s_axis_tuser),
        .i_tdata     (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

>>> tb/tb_adc_offset_gain_trim_engine.sv
`timescale 1ns / 100ps

module tb_adc_offset_gain_trim_engine;
    import aogt_pkg::*;

    localparam int     QUIET_LIMIT  = 4000;
    localparam int     HOLD_CYCLES  = 500;
    localparam int     PHASES       = 8;
    localparam int     PHASE_ITEMS  = 175;
    localparam longint MIDSCALE     = 32768;
    localparam longint WRAP_TOP     = 32767;
    localparam longint WRAP_FLOOR   = 16384;
    localparam longint OFFSET_SAT   = 16383;
    localparam longint GAIN_MAX     = 32768;
    localparam longint FULL_SCALE   = 32767;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [SEL_W-1:0]     sel;
        logic [CODE_W-1:0]    code;
        logic [PRESENT_W-1:0] present;
        logic [VOLT_W-1:0]    volt;
    } trim_req_t;

    typedef struct packed {
        logic [TRIM_W-1:0]   trim;
        logic [OFFSET_W-1:0] offs;
        logic [GAIN_W-1:0]   gain;
        logic                illegal;
        logic                clamped;
    } trim_resp_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // own copy of the block state
    logic [REF_W-1:0]    ref_scale_q = REF_SCALE_RESET;
    logic [BIAS_W-1:0]   bias_q = BIAS_RESET;
    logic [OFFSET_W-1:0] offset_trims [GAIN_SETTINGS_DEFAULT] = '{default: '0};
    logic [GAIN_W-1:0]   gain_trims [GAIN_SETTINGS_DEFAULT] = '{default: UNITY_GAIN};
    int                  pga_doubled [8] = '{2, 3, 4, 8, 18, 2, 2, 2};

    trim_req_t  trim_reqs [$];
    trim_resp_t expected_trims [$];
    trim_req_t  send_cur;
    trim_resp_t mon_got;
    trim_resp_t mon_want;

    int send_mode = 2;
    int recv_mode = 2;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_left = 0;
    bit send_busy = 1'b0;
    bit stall_burst_req = 1'b0;

    int mismatches = 0;
    int results_checked = 0;
    int illegal_seen = 0;
    int clamped_seen = 0;
    int settings_used = 1;
    int cmd_count [4] = '{default: 0};

    adc_offset_gain_trim_engine #(
        .GAIN_SETTINGS(GAIN_SETTINGS_DEFAULT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_wait(int mode);
        if (mode == 0) return 0;
        if (mode == 1) return $urandom_range(0, 17);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
    endfunction

    function automatic trim_resp_t predict_trim(trim_req_t rq);
        trim_resp_t r;
        int         slot;
        logic       has_slot;
        longint     pres, code, step, wrapped, num, tgt, meas, q;
        r = '0;
        has_slot = rq.sel < GAIN_SETTINGS_DEFAULT;
        slot = has_slot ? int'(rq.sel) : 0;
        pres = longint'(rq.present);
        code = longint'(rq.code);
        q = 0;
        case (rq.cmd)
            CMD_OFFSET: begin
                q = pres;
                if (code > MIDSCALE) begin
                    step = (code - MIDSCALE) * 4;
                    if (pres >= step) begin
                        q = pres - step;
                    end else begin
                        wrapped = WRAP_TOP - step + pres;
                        if (wrapped < WRAP_FLOOR) begin
                            q = WRAP_FLOOR;
                            r.clamped = 1'b1;
                        end else begin
                            q = wrapped;
                        end
                    end
                end else if (code < MIDSCALE) begin
                    step = (MIDSCALE - code) * 4;
                    q = (pres + step > OFFSET_SAT) ? OFFSET_SAT : pres + step;
                end
                r.trim = TRIM_W'(q);
                if (has_slot) offset_trims[slot] = q[OFFSET_W-1:0];
            end
            CMD_GAIN: begin
                if (ref_scale_q != 0) begin
                    num = (longint'(rq.volt) - longint'(bias_q)) * FULL_SCALE
                          * pga_doubled[rq.sel];
                    tgt = num / (longint'(ref_scale_q) * 2);
                    meas = code - MIDSCALE;
                    if (meas == tgt) q = pres;
                    else if (meas != 0) q = pres * tgt / meas;
                end
                if (q <= 0 || q > GAIN_MAX) begin
                    r.illegal = 1'b1;
                    r.trim = ILLEGAL_GAIN_CODE;
                end else begin
                    r.trim = TRIM_W'(q);
                end
                if (has_slot) gain_trims[slot] = r.trim;
            end
            default: ;
        endcase
        r.offs = offset_trims[slot];
        r.gain = gain_trims[slot];
        return r;
    endfunction

    // voltage whose target code stays inside the adc range
    function automatic logic [VOLT_W-1:0] volt_near_bias(logic [SEL_W-1:0] sel);
        int span;
        int v;
        span = int'(ref_scale_q) * 2 / pga_doubled[sel];
        v = int'(bias_q) + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0) v = 0;
        if (v > 131071) v = 131071;
        return VOLT_W'(v);
    endfunction

    // adc code measuring num/den of the target code
    function automatic logic [CODE_W-1:0] code_at_ratio(logic [SEL_W-1:0] sel,
            logic [VOLT_W-1:0] volt, int num, int den);
        longint tgt;
        longint meas;
        if (ref_scale_q == 0) return CODE_W'($urandom);
        tgt = ((longint'(volt) - longint'(bias_q)) * FULL_SCALE * pga_doubled[sel])
              / (longint'(ref_scale_q) * 2);
        meas = tgt * num / den;
        if (meas > 32767) meas = 32767;
        if (meas < -32768) meas = -32768;
        return CODE_W'(meas + MIDSCALE);
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (mismatches < 100)
            $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
                     results_checked, field, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
            input logic [CODE_W-1:0] code, input logic [PRESENT_W-1:0] present,
            input logic [VOLT_W-1:0] volt);
        trim_req_t rq;
        rq.cmd = cmd;
        rq.sel = sel;
        rq.code = code;
        rq.present = present;
        rq.volt = volt;
        trim_reqs.push_back(rq);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_REF_SCALE) ref_scale_q = val[REF_W-1:0];
        else bias_q = val[BIAS_W-1:0];
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (trim_reqs.size() != 0 || send_busy || expected_trims.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_trims.push_back(predict_trim(send_cur));
                cmd_count[send_cur.cmd]++;
                send_busy = 1'b0;
                send_wait = draw_wait(send_mode);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (trim_reqs.size() != 0) begin
                    send_cur = trim_reqs.pop_front();
                    send_busy = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {send_cur.volt, send_cur.present, send_cur.code};
                    s_axis_tuser <= {send_cur.sel, send_cur.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                mon_got.trim = m_axis_tdata[16:0];
                mon_got.offs = m_axis_tdata[31:17];
                mon_got.gain = m_axis_tdata[48:32];
                mon_got.illegal = m_axis_tuser[0];
                mon_got.clamped = m_axis_tuser[1];
                if (expected_trims.size() == 0) begin
                    report_mismatch("unexpected item, new_trim", mon_got.trim, 0);
                end else begin
                    mon_want = expected_trims.pop_front();
                    if (mon_got.trim !== mon_want.trim)
                        report_mismatch("new_trim", mon_got.trim, mon_want.trim);
                    if (mon_got.offs !== mon_want.offs)
                        report_mismatch("stored_offset", mon_got.offs, mon_want.offs);
                    if (mon_got.gain !== mon_want.gain)
                        report_mismatch("stored_gain", mon_got.gain, mon_want.gain);
                    if (mon_got.illegal !== mon_want.illegal)
                        report_mismatch("illegal_gain", mon_got.illegal, mon_want.illegal);
                    if (mon_got.clamped !== mon_want.clamped)
                        report_mismatch("offset_clamped", mon_got.clamped, mon_want.clamped);
                    if (mon_want.illegal) illegal_seen++;
                    if (mon_want.clamped) clamped_seen++;
                end
                results_checked++;
                recv_wait = draw_wait(recv_mode);
            end
            if (stall_burst_req) begin
                stall_burst_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_adc_offset_gain_trim_engine: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [CMD_W-1:0]     cmd;
        logic [SEL_W-1:0]     sel;
        logic [CODE_W-1:0]    code;
        logic [PRESENT_W-1:0] present;
        logic [VOLT_W-1:0]    volt;
        int                   kind;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items at the reset register values
        queue_item(CMD_READ, 3'd0, 16'd0, 15'd0, 17'd0);
        queue_item(CMD_READ, 3'd4, 16'hFFFF, 15'h7FFF, 17'h1FFFF);
        queue_item(CMD_OFFSET, 3'd0, 16'd32768, 15'd1234, 17'd0);
        queue_item(CMD_OFFSET, 3'd1, 16'hFFFF, 15'd0, 17'd0);
        queue_item(CMD_OFFSET, 3'd2, 16'd32770, 15'd3, 17'd0);
        queue_item(CMD_OFFSET, 3'd3, 16'd32769, 15'h7FFF, 17'd0);
        queue_item(CMD_OFFSET, 3'd4, 16'd0, 15'd0, 17'd0);
        queue_item(CMD_OFFSET, 3'd0, 16'd32767, 15'd100, 17'd0);
        queue_item(CMD_OFFSET, 3'd6, 16'd30000, 15'd500, 17'd0);
        queue_item(CMD_READ, 3'd7, 16'd0, 15'd0, 17'd0);
        queue_item(CMD_GAIN, 3'd0, 16'd32768, 15'd0, BIAS_RESET);
        queue_item(CMD_GAIN, 3'd1, 16'd32768, 15'd12345, BIAS_RESET);
        queue_item(CMD_GAIN, 3'd2, 16'd32768, 15'd16384, 17'h1FFFF);
        queue_item(CMD_GAIN, 3'd3, 16'd40000, 15'd16384, 17'd0);
        queue_item(CMD_GAIN, 3'd0, code_at_ratio(3'd0, 17'h1FFFF, 1, 2), 15'h7FFF, 17'h1FFFF);
        volt = volt_near_bias(3'd4);
        queue_item(CMD_GAIN, 3'd4, code_at_ratio(3'd4, volt, 3, 4), 15'd12000, volt);
        volt = volt_near_bias(3'd1);
        queue_item(CMD_GAIN, 3'd1, code_at_ratio(3'd1, volt, 5, 4), 15'd9000, volt);
        volt = volt_near_bias(3'd5);
        queue_item(CMD_GAIN, 3'd5, code_at_ratio(3'd5, volt, 7, 8), 15'd15000, volt);
        queue_item(CMD_GAIN, 3'd7, 16'hFFFF, 15'h7FFF, 17'h1FFFF);
        queue_item(CMD_SPARE, 3'd2, 16'd0, 15'd0, 17'd0);
        queue_item(CMD_SPARE, 3'd7, 16'hFFFF, 15'h7FFF, 17'h1FFFF);
        queue_item(CMD_READ, 3'd3, 16'd0, 15'd0, 17'd0);
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_REF_SCALE, 18'h3FFFF);
                    write_reg(CFG_BIAS, 18'd0);
                end
                1: begin
                    write_reg(CFG_REF_SCALE, 18'd1);
                    write_reg(CFG_BIAS, 18'h1FFFF);
                end
                2: begin
                    write_reg(CFG_REF_SCALE, 18'd0);
                    write_reg(CFG_BIAS, CFG_DATA_W'($urandom_range(0, 131071)));
                end
                PHASES - 1: begin
                    write_reg(CFG_REF_SCALE, REF_SCALE_RESET);
                    write_reg(CFG_BIAS, CFG_DATA_W'(BIAS_RESET));
                end
                default: begin
                    write_reg(CFG_REF_SCALE, CFG_DATA_W'($urandom_range(1, 262143)));
                    write_reg(CFG_BIAS, CFG_DATA_W'($urandom_range(0, 131071)));
                end
            endcase
            settings_used++;
            send_mode = phase % 3;
            recv_mode = (phase + 2) % 3;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(0, 99);
                sel = ($urandom_range(0, 7) == 0) ? SEL_W'($urandom_range(5, 7))
                                                  : SEL_W'($urandom_range(0, 4));
                code = CODE_W'($urandom);
                present = PRESENT_W'($urandom);
                volt = VOLT_W'($urandom);
                if (kind < 40) begin
                    // well-formed gain calibration
                    cmd = CMD_GAIN;
                    volt = volt_near_bias(sel);
                    present = PRESENT_W'($urandom_range(1, 16384));
                    if (kind < 6) code = code_at_ratio(sel, volt, 1, 1);
                    else code = code_at_ratio(sel, volt, $urandom_range(512, 2048), 1024);
                end else if (kind < 50) begin
                    cmd = CMD_GAIN;
                end else if (kind < 80) begin
                    cmd = CMD_OFFSET;
                    if (kind < 65)
                        code = CODE_W'(32768 + int'($urandom_range(0, 8192)) - 4096);
                    else if (kind < 68)
                        code = CODE_W'(MIDSCALE);
                end else if (kind < 95) begin
                    cmd = CMD_READ;
                end else begin
                    cmd = CMD_SPARE;
                end
                queue_item(cmd, sel, code, present, volt);
            end
            if (phase == 1 || phase == 5) stall_burst_req = 1'b1;
            wait_idle();
        end

        repeat (100) @(posedge i_clk);
        $display("covered %0d read, %0d offset, %0d gain, %0d spare items over %0d settings",
                 cmd_count[CMD_READ], cmd_count[CMD_OFFSET], cmd_count[CMD_GAIN],
                 cmd_count[CMD_SPARE], settings_used);
        $display("%0d results checked, %0d illegal gain, %0d clamped offset, %0d mismatches",
                 results_checked, illegal_seen, clamped_seen, mismatches);
        if (mismatches == 0)
            $display("tb_adc_offset_gain_trim_engine: done, clean");
        else
            $display("tb_adc_offset_gain_trim_engine: done, errors");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/aogt_pkg.sv
hw/rtl/aogt_divider.sv
hw/rtl/aogt_datapath.sv
hw/rtl/aogt_ctrl.sv
hw/rtl/adc_offset_gain_trim_engine.sv
tb/tb_adc_offset_gain_trim_engine.sv
